// ----- design/biquad_cascade_lowpass_q15_core_macros.svh -----
// ----------------------------------------------------------------------------
// biquad cascade assertion macros
// shared property wrappers, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef BIQUAD_CASCADE_LOWPASS_Q15_CORE_MACROS_SVH
`define BIQUAD_CASCADE_LOWPASS_Q15_CORE_MACROS_SVH

// plain property check
`define BCL_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication checked in the same cycle
`define BCL_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// implication checked in the next cycle
`define BCL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/bcl_pkg.sv -----
// ----------------------------------------------------------------------------
// bcl_pkg
// shared constants and types of the cascaded low-pass biquad core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcl_pkg;

   // number of cascaded sections
   localparam int SECTIONS = 4;
   // number of coefficient registers
   localparam int NUM_REGS = 4;

   localparam int SAMPLE_W  = 16;
   localparam int REG_W     = 48;
   localparam int REG_IDX_W = 2;
   localparam int SEC_W     = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

   // delay entry: w2 in the upper half, w1 in the lower half
   localparam int DELAY_W   = 2 * SAMPLE_W;
   // sum w0 + 2*w1 + w2 and the full product with the gain
   localparam int SUM_W     = SAMPLE_W + 3;
   localparam int PROD_W    = SAMPLE_W + SUM_W;

   typedef logic signed [SAMPLE_W-1:0]        sample_type;
   typedef logic [REG_W-1:0]                  coef_type;
   typedef logic [NUM_REGS-1:0][REG_W-1:0]    coef_array_type;
   typedef logic [SEC_W-1:0]                  sec_type;

endpackage

// ----- design/bcl_req_if.sv -----
// ----------------------------------------------------------------------------
// bcl_req_if
// input sample channel: valid, ready and one sample per beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bcl_req_if import bcl_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

// ----- design/bcl_rsp_if.sv -----
// ----------------------------------------------------------------------------
// bcl_rsp_if
// filtered sample channel: valid, ready and one sample per beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bcl_rsp_if import bcl_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

// ----- design/bcl_ram.sv -----
// ----------------------------------------------------------------------------
// bcl_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcl_ram #(
   parameter int DEPTH = 4,
   parameter int WIDTH = 32
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/bcl_csr.sv -----
// ----------------------------------------------------------------------------
// bcl_csr
// coefficient register file, one packed gain/d1/d2 word per section
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcl_csr import bcl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [REG_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_wdata,
   output coef_array_type       coefs
);

   coef_array_type coef_ff;

   // register writes, out-of-range indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else if (csr_wr_en && (32'(csr_index) < NUM_REGS)) begin
         coef_ff[csr_index] <= csr_wdata;
      end
   end

   assign coefs = coef_ff;

endmodule

// ----- design/bcl_engine.sv -----
// ----------------------------------------------------------------------------
// bcl_engine
// section sequencer: reads delays, runs a shared multiplier, writes back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "biquad_cascade_lowpass_q15_core_macros.svh"

module bcl_engine import bcl_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   bcl_req_if.sink        req_chan,
   bcl_rsp_if.source      rsp_chan,
   input  coef_array_type coefs
);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_MUL1 = 7'b0000010,
      ST_MUL2 = 7'b0000100,
      ST_SUM  = 7'b0001000,
      ST_MUL3 = 7'b0010000,
      ST_XFER = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

   state_type                 state_ff, state_in;
   sec_type                   sec_ff, sec_in;
   sample_type                x_ff, x_in;
   logic signed [SAMPLE_W-1:0] w1_ff, w1_in, w2_ff, w2_in;
   logic [SAMPLE_W-1:0]       acc_ff, acc_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic [SECTIONS-1:0]       vld_ff, vld_in;
   logic                      rd_vld_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   sample_type                rsp_data_ff, rsp_data_in;

   logic signed [SAMPLE_W-1:0] mul_a;
   logic signed [SUM_W-1:0]    mul_b;
   coef_type                   coef_sel;
   logic signed [SAMPLE_W-1:0] c_gain, c_d1, c_d2;
   logic [SAMPLE_W-1:0]        w0;
   logic [DELAY_W-1:0]         rd_data;
   logic                       ram_we;
   logic                       last_sec;
   logic                       accept;
   logic                       rsp_load;

   // delay store, entry = {w2, w1}
   bcl_ram #(
      .DEPTH (SECTIONS),
      .WIDTH (DELAY_W)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (sec_ff),
      .wr_data ({w1_ff, w0}),
      .rd_addr (sec_in),
      .rd_data (rd_data)
   );

   // coefficients of the current section, zero beyond the register file
   always_comb begin
      coef_sel = '0;
      for (int r = 0; r < NUM_REGS; r++) begin
         if (32'(sec_ff) == r) begin
            coef_sel = coefs[r];
         end
      end
   end

   assign c_gain = coef_sel[SAMPLE_W-1:0];
   assign c_d1   = coef_sel[2*SAMPLE_W-1:SAMPLE_W];
   assign c_d2   = coef_sel[3*SAMPLE_W-1:2*SAMPLE_W];

   assign last_sec = (32'(sec_ff) == SECTIONS - 1);
   assign accept   = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   // new w0: bits 30:15 of the d2 product added to the running sum
   assign w0     = acc_ff + prod_ff[SAMPLE_W+14:15];
   assign ram_we = (state_ff == ST_SUM);

   // shared multiplier operand select
   always_comb begin
      mul_a = c_gain;
      mul_b = sum_ff;
      case (state_ff)
         ST_MUL1: begin
            mul_a = c_d1;
            mul_b = SUM_W'(w1_in);
         end
         ST_MUL2: begin
            mul_a = c_d2;
            mul_b = SUM_W'(w2_ff);
         end
         default: begin
            mul_a = c_gain;
            mul_b = sum_ff;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   assign rsp_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      sec_in       = sec_ff;
      x_in         = x_ff;
      w1_in        = w1_ff;
      w2_in        = w2_ff;
      acc_in       = acc_ff;
      sum_in       = sum_ff;
      vld_in       = vld_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      unique case (state_ff)
         ST_IDLE: begin
            sec_in = '0;
            if (accept) begin
               x_in     = req_chan.sample_in;
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            // delays arrive from the ram, never-written entries read as zero
            w1_in    = rd_vld_ff ? rd_data[SAMPLE_W-1:0] : '0;
            w2_in    = rd_vld_ff ? rd_data[DELAY_W-1:SAMPLE_W] : '0;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            acc_in   = prod_ff[SAMPLE_W+13:14] + SAMPLE_W'(x_ff >>> 3);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            sum_in   = SUM_W'($signed(w0)) + (SUM_W'(w1_ff) <<< 1) + SUM_W'(w2_ff);
            vld_in[sec_ff] = 1'b1;
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            state_in = ST_XFER;
         end
         ST_XFER: begin
            // take bits 26:12 of the gain product, shifted up one place
            x_in = {prod_ff[SAMPLE_W+10:12], 1'b0};
            if (last_sec) begin
               state_in = ST_OUT;
            end else begin
               sec_in   = sec_ff + SEC_W'(1);
               state_in = ST_MUL1;
            end
         end
         ST_OUT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = x_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sec_ff       <= '0;
         vld_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sec_ff       <= sec_in;
         vld_ff       <= vld_in;
         rd_vld_ff    <= vld_ff[sec_in];
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      w1_ff       <= w1_in;
      w2_ff       <= w2_in;
      acc_ff      <= acc_in;
      sum_ff      <= sum_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.sample_out = rsp_data_ff;

   // section counter stays inside the cascade
   `BCL_ASSERT(a_sec_range, 32'(sec_ff) < SECTIONS, "section index out of range")
   // a result only appears from the output state
   `BCL_ASSERT_IMP(a_rsp_source, $rose(rsp_valid_ff), $past(state_ff == ST_OUT),
                   "result raised outside output state")
   // the last section hands over to the output state
   `BCL_ASSERT_NEXT(a_last_out, (state_ff == ST_XFER) && last_sec, state_ff == ST_OUT,
                    "last section did not finish the sample")
   // leaving the output state always leaves a result waiting
   `BCL_ASSERT_NEXT(a_out_loaded, (state_ff == ST_OUT) && (state_in == ST_IDLE),
                    rsp_valid_ff, "output state left without a result")

endmodule

// ----- design/biquad_cascade_lowpass_q15_core.sv -----
// ----------------------------------------------------------------------------
// biquad_cascade_lowpass_q15_core
// cascaded direct-form-ii low-pass biquads on signed q1.15 samples
// ----------------------------------------------------------------------------
// usage
//   req_chan carries one q1.15 sample per beat; rsp_chan returns one filtered
//   sample per accepted beat, in order.
//   csr_wr_en/csr_index/csr_wdata write the packed gain, d1, d2 word of a
//   section (gain in bits 15:0, d1 in 31:16, d2 in 47:32); write only while
//   the core is idle.
//   each section steps through MUL1, MUL2, SUM, MUL3 and XFER on the one
//   shared 16x19 multiplier (d1*w1, d2*w2, gain*sum) with its delays read
//   from and written back to a small ram; a sample is taken only while the
//   core is idle, and the next sample is taken in the cycle after the
//   result is handed to the output register.
//   a finished result waits in the output register, so a new sample is
//   accepted while rsp_chan is stalled; a second result waits in the core
//   until the register frees.
//   reset clears the coefficients to zero and marks every delay entry as
//   zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module biquad_cascade_lowpass_q15_core import bcl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   bcl_req_if.sink              req_chan,
   bcl_rsp_if.source            rsp_chan,
   input  logic                 csr_wr_en,
   input  logic [REG_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_wdata
);

   coef_array_type coefs;

   // coefficient registers
   bcl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coefs     (coefs)
   );

   // section sequencer and delay store
   bcl_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .coefs    (coefs)
   );

endmodule
